/* rtl/core/assert_macros.svh */
// Assertion macros shared by the subband requantizer checkers.
// Taken in by files that hold concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property at every clock edge outside reset.
`define LSR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check a property at every clock edge, reset included.
`define LSR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

/* rtl/core/lsr_pkg.sv */
// Shared types, constants and lookup functions of the subband requantizer.
// No dependencies; imported by the interfaces and every module of the block.
package lsr_pkg;

  // Field widths
  localparam int unsigned CwWidth     = 16;
  localparam int unsigned ClsWidth    = 5;
  localparam int unsigned ScaleWidth  = 6;
  localparam int unsigned SampleWidth = 32;
  localparam int unsigned NumClasses  = 18;

  // Grouped codewords are at most 10 bits, unpacked values fit 4 bits
  localparam int unsigned GrpWidth    = 10;
  localparam int unsigned GrpRemWidth = 4;
  localparam int unsigned RecipWidth  = 11;
  localparam int unsigned RecipShift  = 12;

  // Datapath widths
  localparam int unsigned MagWidth      = 17;
  localparam int unsigned MantWidth     = 32;
  localparam int unsigned ProdWidth     = 48;
  localparam int unsigned ExpWidth      = 5;
  localparam int unsigned QuoWidth      = 30;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned DivStages     = QuoWidth / StepsPerStage;

  // Request queue between front and back
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned QueuePtrWidth = 1;
  localparam int unsigned QueueCntWidth = 2;

  // Class codes with special meaning
  localparam logic [ClsWidth-1:0] ClsNone = 5'd0;
  localparam logic [ClsWidth-1:0] ClsGrp3 = 5'd1;
  localparam logic [ClsWidth-1:0] ClsGrp5 = 5'd2;
  localparam logic [ClsWidth-1:0] ClsGrp9 = 5'd4;

  // Level count of each class
  localparam logic [CwWidth-1:0] LvlTab [NumClasses] = '{
    16'd0, 16'd3, 16'd5, 16'd7, 16'd9, 16'd15, 16'd31, 16'd63, 16'd127,
    16'd255, 16'd511, 16'd1023, 16'd2047, 16'd4095, 16'd8191, 16'd16383,
    16'd32767, 16'd65535
  };

  // Codeword bit mask of each class
  localparam logic [CwWidth-1:0] MaskTab [NumClasses] = '{
    16'h0000, 16'h001F, 16'h007F, 16'h0007, 16'h03FF, 16'h000F, 16'h001F,
    16'h003F, 16'h007F, 16'h00FF, 16'h01FF, 16'h03FF, 16'h07FF, 16'h0FFF,
    16'h1FFF, 16'h3FFF, 16'h7FFF, 16'hFFFF
  };

  // Scalefactor mantissas in Q30: 2, 4^(1/3), 2^(1/3)
  localparam logic [MantWidth-1:0] MantTab [3] = '{
    32'd2147483648, 32'd1704458901, 32'd1352829926
  };

  typedef enum logic [2:0] {
    FE_IDLE,
    FE_SINGLE,
    FE_GRP0,
    FE_GRP1,
    FE_GRP2
  } lsr_fe_state_e;

  // One value request from the front to the back
  typedef struct packed {
    logic [CwWidth-1:0]    value;
    logic [ClsWidth-1:0]   cls;
    logic [ScaleWidth-1:0] scale;
    logic                  last;
  } lsr_req_t;

  typedef struct packed {
    logic [GrpWidth-1:0]    quo;
    logic [GrpRemWidth-1:0] rem;
  } lsr_divmod_t;

  typedef struct packed {
    logic [ExpWidth-1:0] expo;
    logic [1:0]          sel;
  } lsr_scale_t;

  function automatic logic lsr_alloc(input logic [ClsWidth-1:0] cls);
    return (cls != ClsNone) && (32'(cls) < NumClasses);
  endfunction

  function automatic logic [CwWidth-1:0] lsr_levels(input logic [ClsWidth-1:0] cls);
    return lsr_alloc(cls) ? LvlTab[cls] : '0;
  endfunction

  function automatic logic [CwWidth-1:0] lsr_mask(input logic [ClsWidth-1:0] cls);
    return lsr_alloc(cls) ? MaskTab[cls] : '0;
  endfunction

  function automatic logic lsr_grouped(input logic [ClsWidth-1:0] cls);
    return (cls == ClsGrp3) || (cls == ClsGrp5) || (cls == ClsGrp9);
  endfunction

  // Divide a grouped codeword by its level count: reciprocal multiply, one fix-up
  function automatic lsr_divmod_t lsr_grp_divmod(input logic [GrpWidth-1:0] c,
                                                 input logic [ClsWidth-1:0] cls);
    logic [RecipWidth-1:0]          recip;
    logic [GrpRemWidth-1:0]         lvl;
    logic [GrpWidth+RecipWidth-1:0] prod;
    logic [GrpWidth-1:0]            quo;
    logic [GrpWidth-1:0]            rem;
    lsr_divmod_t                    res;
    case (cls)
      ClsGrp3: begin
        recip = 11'd1365;
        lvl   = 4'd3;
      end
      ClsGrp5: begin
        recip = 11'd819;
        lvl   = 4'd5;
      end
      ClsGrp9: begin
        recip = 11'd455;
        lvl   = 4'd9;
      end
      default: begin
        recip = '0;
        lvl   = 4'd1;
      end
    endcase
    prod = (GrpWidth+RecipWidth)'(c) * (GrpWidth+RecipWidth)'(recip);
    quo  = GrpWidth'(prod >> RecipShift);
    rem  = c - GrpWidth'(quo * GrpWidth'(lvl));
    if (rem >= GrpWidth'(lvl)) begin
      quo = quo + 1'b1;
      rem = rem - GrpWidth'(lvl);
    end
    res.quo = quo;
    res.rem = GrpRemWidth'(rem);
    return res;
  endfunction

  // Split a scale index into exponent (index / 3) and mantissa select (index mod 3)
  function automatic lsr_scale_t lsr_scale_split(input logic [ScaleWidth-1:0] s);
    logic [11:0]           prod;
    logic [ScaleWidth-1:0] three_e;
    lsr_scale_t            res;
    prod     = 12'(s) * 12'd43;
    res.expo = prod[11:7];
    three_e  = {res.expo, 1'b0} + {1'b0, res.expo};
    res.sel  = 2'(s - three_e);
    return res;
  endfunction

endpackage

/* rtl/core/lsr_if.sv */
// Valid/ready channel interfaces of the subband requantizer: codeword in, sample out.
// Depends on lsr_pkg for field widths.
interface lsr_in_if import lsr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CwWidth-1:0]    codeword;
  logic [ClsWidth-1:0]   class_index;
  logic [ScaleWidth-1:0] scale_index;

  modport source (output valid, codeword, class_index, scale_index, input ready);
  modport sink   (input valid, codeword, class_index, scale_index, output ready);
endinterface

interface lsr_out_if import lsr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] sample;
  logic                          last;

  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

/* rtl/core/lsr_front.sv */
// Front end: accepts codewords, masks them by class and unpacks grouped codes.
// Emits one value request a cycle into the queue while it has room; depends on lsr_pkg.
module lsr_front import lsr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CwWidth-1:0]    codeword_i,
  input  logic [ClsWidth-1:0]   class_index_i,
  input  logic [ScaleWidth-1:0] scale_index_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output lsr_req_t              push_o
);

  lsr_fe_state_e         state_q, state_d;
  logic [CwWidth-1:0]    code_q, code_d;
  logic [ClsWidth-1:0]   cls_q, cls_d;
  logic [ScaleWidth-1:0] scale_q, scale_d;
  lsr_divmod_t           dm;
  logic                  grp_emit;
  logic                  push;
  logic                  accept;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the item being unpacked
  always_ff @(posedge clk_i) begin
    code_q  <= code_d;
    cls_q   <= cls_d;
    scale_q <= scale_d;
  end

  // Emit values, advance through the group, take the next item on the final one
  always_comb begin
    dm       = lsr_grp_divmod(code_q[GrpWidth-1:0], cls_q);
    grp_emit = (state_q == FE_GRP0) || (state_q == FE_GRP1) || (state_q == FE_GRP2);

    push_o.value = grp_emit ? CwWidth'(dm.rem) : code_q;
    push_o.cls   = cls_q;
    push_o.scale = scale_q;
    push_o.last  = (state_q == FE_SINGLE) || (state_q == FE_GRP2);
    push_valid_o = (state_q != FE_IDLE);
    push         = push_valid_o && push_ready_i;

    in_ready_o = (state_q == FE_IDLE) || (push && push_o.last);
    accept     = in_valid_i && in_ready_o;

    state_d = state_q;
    code_d  = code_q;
    cls_d   = cls_q;
    scale_d = scale_q;

    case (state_q)
      FE_GRP0: begin
        if (push) begin
          state_d = FE_GRP1;
          code_d  = CwWidth'(dm.quo);
        end
      end
      FE_GRP1: begin
        if (push) begin
          state_d = FE_GRP2;
          code_d  = CwWidth'(dm.quo);
        end
      end
      FE_SINGLE, FE_GRP2: begin
        if (push) begin
          state_d = FE_IDLE;
        end
      end
      FE_IDLE: begin
        state_d = FE_IDLE;
      end
      default: begin
        state_d = FE_IDLE;
      end
    endcase

    if (accept) begin
      state_d = lsr_grouped(class_index_i) ? FE_GRP0 : FE_SINGLE;
      code_d  = codeword_i & lsr_mask(class_index_i);
      cls_d   = class_index_i;
      scale_d = scale_index_i;
    end
  end

endmodule

/* rtl/core/lsr_fifo.sv */
// Two-entry request queue between the front end and the arithmetic back end.
// Depends on lsr_pkg for the request type and depth.
module lsr_fifo import lsr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  lsr_req_t push_i,
  output logic     pop_valid_o,
  input  logic     pop_i,
  output lsr_req_t pop_o
);

  lsr_req_t                 mem_q [QueueDepth];
  logic [QueuePtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntWidth-1:0] cnt_q;
  logic                     push;
  logic                     pop;

  assign push_ready_o = (cnt_q != QueueCntWidth'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_o        = mem_q[rd_ptr_q];

  // Store requests
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/lsr_back.sv */
// Back end: requantize, scale and round each value in a stalling pipeline.
// Stages: prepare, multiply, round and shift, 15 two-bit divide stages, output.
// Depends on lsr_pkg.
module lsr_back import lsr_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  lsr_req_t                      req_i,
  output logic                          req_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SampleWidth-1:0] sample_o,
  output logic                          last_o
);

  typedef struct packed {
    logic                 alloc;
    logic                 neg;
    logic                 last;
    logic [MagWidth-1:0]  mag;
    logic [CwWidth-1:0]   lvl;
    logic [ExpWidth-1:0]  expo;
    logic [MantWidth-1:0] mant;
  } lsr_prep_t;

  typedef struct packed {
    logic                 alloc;
    logic                 neg;
    logic                 last;
    logic [ProdWidth-1:0] prod;
    logic [CwWidth-1:0]   lvl;
    logic [ExpWidth-1:0]  expo;
  } lsr_prod_t;

  typedef struct packed {
    logic                alloc;
    logic                neg;
    logic                last;
    logic [CwWidth-1:0]  rem;
    logic [QuoWidth-1:0] acc;
    logic [CwWidth-1:0]  lvl;
  } lsr_div_t;

  // Restoring division by the level count, two quotient bits per stage
  function automatic lsr_div_t div_step(input lsr_div_t s);
    lsr_div_t           r;
    logic [CwWidth:0]   t;
    r = s;
    for (int k = 0; k < StepsPerStage; k++) begin
      t     = {r.rem, r.acc[QuoWidth-1]};
      r.acc = {r.acc[QuoWidth-2:0], 1'b0};
      if (t >= {1'b0, r.lvl}) begin
        r.rem    = CwWidth'(t - {1'b0, r.lvl});
        r.acc[0] = 1'b1;
      end else begin
        r.rem = t[CwWidth-1:0];
      end
    end
    return r;
  endfunction

  logic                   adv;
  lsr_prep_t              prep_q, prep_d;
  logic                   prep_vq;
  lsr_prod_t              prod_q, prod_d;
  logic                   prod_vq;
  lsr_div_t               div_q [DivStages+1];
  lsr_div_t               div_d [DivStages+1];
  logic [DivStages:0]     div_vq;
  logic                   out_valid_q;
  logic [SampleWidth-1:0] sample_q, sample_d;
  logic                   last_q;

  logic [CwWidth-1:0]     lvl;
  logic [MagWidth-1:0]    twice;
  lsr_scale_t             sc;
  logic [ProdWidth:0]     prod_full;
  logic [ProdWidth-1:0]   rnd;
  logic [ProdWidth-1:0]   xsum;
  logic [ProdWidth-1:0]   xshift;
  logic [SampleWidth-1:0] qmag;

  // Whole pipeline moves together unless the output register is stalled
  assign adv       = !out_valid_q || out_ready_i;
  assign req_pop_o = req_valid_i && adv;

  // Prepare: signed numerator magnitude, level count, scalefactor parts
  always_comb begin
    lvl          = lsr_levels(req_i.cls);
    twice        = {req_i.value, 1'b1};
    sc           = lsr_scale_split(req_i.scale);
    prep_d.alloc = lsr_alloc(req_i.cls);
    prep_d.neg   = twice < {1'b0, lvl};
    prep_d.mag   = prep_d.neg ? ({1'b0, lvl} - twice) : (twice - {1'b0, lvl});
    prep_d.last  = req_i.last;
    prep_d.lvl   = lvl;
    prep_d.expo  = sc.expo;
    prep_d.mant  = MantTab[sc.sel];
  end

  // Multiply by the scalefactor mantissa
  always_comb begin
    prod_full    = prep_q.mag * prep_q.mant;
    prod_d.alloc = prep_q.alloc;
    prod_d.neg   = prep_q.neg;
    prod_d.last  = prep_q.last;
    prod_d.prod  = prod_full[ProdWidth-1:0];
    prod_d.lvl   = prep_q.lvl;
    prod_d.expo  = prep_q.expo;
  end

  // Add half the divisor, drop the power-of-two part, then divide by the level count
  always_comb begin
    rnd    = ProdWidth'(prod_q.lvl) << ({1'b0, prod_q.expo} + 6'd1);
    xsum   = prod_q.prod + rnd;
    xshift = xsum >> ({1'b0, prod_q.expo} + 6'd2);

    div_d[0].alloc = prod_q.alloc;
    div_d[0].neg   = prod_q.neg;
    div_d[0].last  = prod_q.last;
    div_d[0].rem   = xshift[QuoWidth+CwWidth-1:QuoWidth];
    div_d[0].acc   = xshift[QuoWidth-1:0];
    div_d[0].lvl   = prod_q.lvl;
    for (int i = 1; i <= DivStages; i++) begin
      div_d[i] = div_step(div_q[i-1]);
    end
  end

  // Apply the sign, zero when unallocated
  always_comb begin
    qmag     = {{(SampleWidth-QuoWidth){1'b0}}, div_q[DivStages].acc};
    sample_d = !div_q[DivStages].alloc ? '0 :
               (div_q[DivStages].neg ? (~qmag + 1'b1) : qmag);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_vq     <= 1'b0;
      prod_vq     <= 1'b0;
      div_vq      <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      prep_vq     <= req_valid_i;
      prod_vq     <= prep_vq;
      div_vq      <= {div_vq[DivStages-1:0], prod_vq};
      out_valid_q <= div_vq[DivStages];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      prep_q <= prep_d;
      prod_q <= prod_d;
      for (int i = 0; i <= DivStages; i++) begin
        div_q[i] <= div_d[i];
      end
      sample_q <= sample_d;
      last_q   <= div_q[DivStages].last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign last_o      = last_q;

endmodule

/* rtl/core/layer2_subband_requantizer.sv */
// Top level of the Layer II subband requantizer: front end, request queue, back end.
// Depends on lsr_pkg, lsr_if, lsr_front, lsr_fifo and lsr_back.
//
//   Port    Dir  Handshake      Payload
//   in_i    in   valid / ready  codeword[15:0], class_index[4:0], scale_index[5:0]
//   out_o   out  valid / ready  sample[31:0] signed, last
//
// Results leave at one per cycle while out_o.ready is high. A grouped codeword
// (3, 5, 9 levels) yields three values and every other class one; the front end
// takes the next codeword with the last value. Each value passes a 15-stage divider.
// Reset clears control state only; queue storage and payload registers are kept.
// out_o.ready low freezes the back-end pipeline; the two-entry queue lets the front
// end keep unpacking until it fills.
module layer2_subband_requantizer import lsr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  lsr_in_if.sink    in_i,
  lsr_out_if.source out_o
);

  logic     push_valid;
  logic     push_ready;
  lsr_req_t push_req;
  logic     pop_valid;
  logic     pop;
  lsr_req_t pop_req;

  lsr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .codeword_i    (in_i.codeword),
    .class_index_i (in_i.class_index),
    .scale_index_i (in_i.scale_index),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_o        (push_req)
  );

  lsr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_i       (push_req),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_o        (pop_req)
  );

  lsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (pop_valid),
    .req_i       (pop_req),
    .req_pop_o   (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sample_o    (out_o.sample),
    .last_o      (out_o.last)
  );

endmodule

/* rtl/core/lsr_checker.sv */
// Port-level assertions for the subband requantizer, bound to the top level.
// Depends on lsr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lsr_checker import lsr_pkg::*; (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic [ClsWidth-1:0]           class_index_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic signed [SampleWidth-1:0] sample_i
);

  // Hold a stalled result
  `LSR_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "result withdrawn while stalled")

  // Keep every sample within plus or minus 2^30
  `LSR_ASSERT(a_sample_range, clk_i, rst_ni, out_valid_i |-> (sample_i[31:30] == 2'b00 || sample_i[31:30] == 2'b11), "sample magnitude out of range")

  // Stop taking codewords while a group is being unpacked
  `LSR_ASSERT(a_grp_busy, clk_i, rst_ni, in_valid_i && in_ready_i && (class_index_i == ClsGrp3 || class_index_i == ClsGrp5 || class_index_i == ClsGrp9) |=> !in_ready_i, "grouped codeword not given three cycles")

  // Drop no stale result out of reset
  `LSR_ASSERT_ALWAYS(a_reset_quiet, clk_i, $rose(rst_ni) |-> !out_valid_i, "result shown on leaving reset")

endmodule

bind layer2_subband_requantizer lsr_checker u_lsr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .class_index_i (in_i.class_index),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .sample_i      (out_o.sample)
);
